// File: hdl/pllq_pkg.sv
// Shared types and constants for the pooled linked-list queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package pllq_pkg;

    // Default pool size
    localparam int SLOTS_DEF = 8;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Result codes
    localparam logic [1:0] CODE_DONE    = 2'd0;
    localparam logic [1:0] CODE_FULL    = 2'd1;
    localparam logic [1:0] CODE_MISSING = 2'd2;
    localparam logic [1:0] CODE_EMPTY   = 2'd3;

    // One entry as kept in the payload memory
    typedef struct packed {
        logic [7:0] content;
        logic [7:0] attempts;
        logic [2:0] status;
    } t_entry;

    // Input transaction
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] entry_content;
        logic [7:0] entry_attempts;
        logic [2:0] entry_state;
        logic [2:0] target_slot;
    } t_in;

    // Result transaction
    typedef struct packed {
        logic [1:0] result_code;
        logic [2:0] result_slot;
        logic [7:0] head_content;
        logic [7:0] head_attempts;
        logic [2:0] head_state;
        logic [3:0] entry_count;
    } t_out;

    // Which result the datapath should capture this cycle
    typedef enum logic [2:0] {
        RES_NONE    = 3'd0,
        RES_FULL    = 3'd1,
        RES_APPEND  = 3'd2,
        RES_MISSING = 3'd3,
        RES_DELETED = 3'd4,
        RES_READ    = 3'd5,
        RES_NOP     = 3'd6
    } t_res;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // latch the input transaction, clear scan index
        logic scan_step;  // advance the free-slot scan
        logic store;      // write payload and clear link of the new slot
        logic link;       // hook the new slot onto the tail
        logic walk_init;  // start the list walk at the head
        logic walk_step;  // follow one link
        logic unlink;     // remove the current slot from the list
        t_res res;        // capture a result
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_end;   // scan index ran past the pool
        logic scan_free;  // scan index points at a free slot
        logic target_ok;  // delete target is in range and occupied
        logic walk_end;   // walk has visited every entry
        logic walk_hit;   // walk stands on the target
    } t_stat;

endpackage

`default_nettype wire

// File: hdl/pllq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package needed.
`default_nettype none

module pllq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hdl/pllq_ctrl.sv
// Controller state machine of the pooled linked-list queue.
// Depends on pllq_pkg for command, status and mode definitions.
`default_nettype none

module pllq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire logic [1:0]     i_mode,
    input  wire pllq_pkg::t_stat i_stat,
    output pllq_pkg::t_cmd      o_cmd,
    output logic                busy,
    output logic                o_done
);

    import pllq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_STORE = 7'b0000100,
        S_LINK  = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_READ  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;
    logic   r_done;

    // Sequence the operations
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        cmd.res = RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    case (i_mode)
                        MODE_APPEND: n_state = S_SCAN;
                        MODE_DELETE: n_state = S_CHECK;
                        MODE_READ:   n_state = S_READ;
                        default:     cmd.res = RES_NOP;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    cmd.res = RES_FULL;
                    n_state = S_IDLE;
                end else if (i_stat.scan_free) begin
                    n_state = S_STORE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_STORE: begin
                cmd.store = 1'b1;
                n_state   = S_LINK;
            end
            S_LINK: begin
                cmd.link = 1'b1;
                cmd.res  = RES_APPEND;
                n_state  = S_IDLE;
            end
            S_CHECK: begin
                if (i_stat.target_ok) begin
                    cmd.walk_init = 1'b1;
                    n_state       = S_WALK;
                end else begin
                    cmd.res = RES_MISSING;
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                if (i_stat.walk_end) begin
                    cmd.res = RES_MISSING;
                    n_state = S_IDLE;
                end else if (i_stat.walk_hit) begin
                    cmd.unlink = 1'b1;
                    cmd.res    = RES_DELETED;
                    n_state    = S_IDLE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_READ: begin
                cmd.res = RES_READ;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and pulse the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (cmd.res != RES_NONE);
        end
    end

    assign o_cmd  = cmd;
    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: hdl/pllq_dpath.sv
// Datapath of the pooled linked-list queue: occupancy bitmap, list pointers,
// walk and scan registers, payload and link memories. Uses pllq_pkg, pllq_ram.
`default_nettype none

module pllq_dpath #(
    parameter int SLOTS = pllq_pkg::SLOTS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire pllq_pkg::t_in   i_in,
    input  wire pllq_pkg::t_cmd  i_cmd,
    output pllq_pkg::t_stat      o_stat,
    output pllq_pkg::t_out       o_out
);

    import pllq_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = SW + 1;

    // List state
    logic [SLOTS-1:0] r_occ, n_occ;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_len, n_len;

    // Working registers
    t_in              r_in;
    logic [CW-1:0]    r_idx;
    logic [SW-1:0]    r_cur, n_cur;
    logic [SW-1:0]    r_pred;
    logic [CW-1:0]    r_step;
    t_out             r_out, n_out;

    // Memory ports
    logic             link_we;
    logic [SW-1:0]    link_waddr, link_wdata, link_rdata;
    t_entry           pay_wdata, pay_rdata;
    logic [SW-1:0]    slot;
    logic [SW-1:0]    target;
    logic             target_range;

    assign slot         = r_idx[SW-1:0];
    assign target       = SW'(r_in.target_slot);
    assign target_range = (32'(r_in.target_slot) < SLOTS);

    // Status toward the controller
    assign o_stat.scan_end  = (r_idx == CW'(SLOTS));
    assign o_stat.scan_free = !r_occ[slot];
    assign o_stat.target_ok = target_range && r_occ[target];
    assign o_stat.walk_end  = (r_step == r_len);
    assign o_stat.walk_hit  = (r_cur == target);

    // Update list pointers and bitmap
    always_comb begin
        n_occ  = r_occ;
        n_head = r_head;
        n_tail = r_tail;
        n_len  = r_len;
        n_cur  = r_cur;
        if (i_cmd.store) begin
            n_occ[slot] = 1'b1;
        end
        if (i_cmd.link) begin
            if (r_len == '0) begin
                n_head = slot;
            end
            n_tail = slot;
            n_len  = r_len + CW'(1);
        end
        if (i_cmd.walk_init) begin
            n_cur = r_head;
        end
        if (i_cmd.walk_step) begin
            n_cur = link_rdata;
        end
        if (i_cmd.unlink) begin
            if (r_cur == r_head) begin
                n_head = link_rdata;
            end
            if (r_cur == r_tail) begin
                n_tail = r_pred;
            end
            n_occ[r_cur] = 1'b0;
            n_len        = r_len - CW'(1);
            if (r_len == CW'(1)) begin
                n_head = '0;
                n_tail = '0;
            end
        end
    end

    // Drive the link memory write port
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_cur;
        link_wdata = '0;
        if (i_cmd.store) begin
            link_we    = 1'b1;
            link_waddr = slot;
        end else if (i_cmd.link && r_len != '0) begin
            link_we    = 1'b1;
            link_waddr = r_tail;
            link_wdata = slot;
        end else if (i_cmd.unlink && r_cur != r_head) begin
            link_we    = 1'b1;
            link_waddr = r_pred;
            link_wdata = link_rdata;
        end
    end

    assign pay_wdata.content  = r_in.entry_content;
    assign pay_wdata.attempts = r_in.entry_attempts;
    assign pay_wdata.status   = r_in.entry_state;

    // Build the result transaction
    always_comb begin
        n_out             = '0;
        n_out.result_code = CODE_DONE;
        n_out.entry_count = 4'(n_len);
        case (i_cmd.res)
            RES_FULL:    n_out.result_code = CODE_FULL;
            RES_APPEND:  n_out.result_slot = 3'(slot);
            RES_MISSING: n_out.result_code = CODE_MISSING;
            RES_READ: begin
                if (r_len == '0) begin
                    n_out.result_code = CODE_EMPTY;
                end else begin
                    n_out.result_slot   = 3'(r_head);
                    n_out.head_content  = pay_rdata.content;
                    n_out.head_attempts = pay_rdata.attempts;
                    n_out.head_state    = pay_rdata.status;
                end
            end
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_len  <= '0;
        end else begin
            r_occ  <= n_occ;
            r_head <= n_head;
            r_tail <= n_tail;
            r_len  <= n_len;
        end
    end

    // Working registers and result
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (i_cmd.load) begin
            r_in  <= i_in;
            r_idx <= '0;
        end
        if (i_cmd.scan_step) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.walk_init) begin
            r_pred <= r_head;
            r_step <= '0;
        end
        if (i_cmd.walk_step) begin
            r_pred <= r_cur;
            r_step <= r_step + CW'(1);
        end
        if (i_cmd.res != RES_NONE) begin
            r_out <= n_out;
        end
    end

    // Payload memory: read address follows the head
    pllq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOTS)
    ) u_pay_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (slot),
        .i_wdata (pay_wdata),
        .i_raddr (r_head),
        .o_rdata (pay_rdata)
    );

    // Link memory: read address follows the walk pointer
    pllq_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (n_cur),
        .o_rdata (link_rdata)
    );

    assign o_out = r_out;

endmodule

`default_nettype wire

// File: hdl/pooled_linked_list_queue.sv
// Top level of the pooled linked-list queue: controller plus datapath.
// Depends on pllq_pkg, pllq_ctrl, pllq_dpath and pllq_ram.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ----------------------
//   command   start / busy           i_in  (pllq_pkg::t_in)
//   result    o_done (1-cycle pulse)  o_out (pllq_pkg::t_out)
//
// A command is taken at a clock edge with start high and busy low; each one
// gives exactly one result, shown for one cycle with o_done high.
// Append scans the occupancy bitmap one slot per cycle; delete follows one
// link per cycle through the link RAM's registered read; read returns the
// head entry through the payload RAM's registered read; the unused mode 3
// gives a done result from idle. Reset is synchronous, active low, and
// empties the list at once. The receiver cannot stall; a new command may be
// taken in the cycle its predecessor's result is shown.
`default_nettype none

module pooled_linked_list_queue #(
    parameter int SLOTS = pllq_pkg::SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pllq_pkg::t_in i_in,
    output logic               o_done,
    output pllq_pkg::t_out     o_out
);

    import pllq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequence operations
    pllq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_in.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Hold list state and memories
    pllq_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
